// File: rtl/stid_pkg.sv
// shared types and constants for the sorted table insert/delete unit
// no dependencies; imported by stid_store and sorted_table_insert_delete_unit
package stid_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [4:0]         count;
    logic signed [31:0] smallest;
  } out_t;

  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         addr;
    logic signed [31:0]       data;
  } wr_t;

endpackage

// File: rtl/sorted_table_insert_delete_unit.sv
// top level of the sorted table insert/delete unit
// depends on stid_pkg and stid_store
//
// channel   ports                  handshake
// --------  ---------------------  ---------------------------------------
// command   cmd (in_t)             beat taken when start && !busy
// result    result (out_t)         beat shown for one cycle while done high
//
// one command beat gives exactly one result beat
// an insert walks down from the end, one entry per step (memory read,
// then compare and move); a delete scans up the same way and then moves
// the tail down, reading then writing each entry; the registered read port
// sets the pace; an insert into a full table is dropped and a delete on an
// empty table goes straight to the result
// rst (synchronous) empties the table; entry contents are not cleared
// busy rises once the command beat is taken and stays high through the result cycle; results
// cannot be held off by the receiver
module sorted_table_insert_delete_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  stid_pkg::in_t  cmd,
  output logic           busy,
  output logic           done,
  output stid_pkg::out_t result
);
  import stid_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_CMP,
    S_SHF_RD,
    S_SHF_WR,
    S_DONE
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   k;
  logic signed [31:0] val;
  status_t            status;

  logic [CNT_W-1:0]   k_dec;
  logic [CNT_W-1:0]   k_inc;
  logic [CNT_W-1:0]   k_inc2;
  logic [IDX_W-1:0]   raddr;
  logic signed [31:0] rdata;
  logic signed [31:0] head;
  wr_t                wr;

  assign k_dec  = k - CNT_W'(1);
  assign k_inc  = k + CNT_W'(1);
  assign k_inc2 = k + CNT_W'(2);

  stid_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata),
    .head  (head)
  );

  // read address: entry below k on the insert walk, k on the scan, k+1 on the move
  always_comb begin
    unique case (state)
      S_INS_RD: raddr = k_dec[IDX_W-1:0];
      S_SHF_RD: raddr = k_inc[IDX_W-1:0];
      default:  raddr = k[IDX_W-1:0];
    endcase
  end

  // write port: insert compare moves entries up, put writes val, move copies tail
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = k[IDX_W-1:0];
    wr.data = val;
    unique case (state)
      S_INS_CMP: begin
        if (rdata >= val) begin
          wr.en   = 1'b1;
          wr.data = rdata;
        end
      end
      S_INS_PUT: begin
        wr.en = 1'b1;
      end
      S_SHF_WR: begin
        wr.en   = 1'b1;
        wr.data = rdata;
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      k      <= '0;
      val    <= '0;
      status <= ST_INSERTED;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            val <= cmd.value;
            if (cmd.action == ACT_INSERT) begin
              k <= fill;
              if (fill == CNT_W'(CAPACITY)) begin
                status <= ST_FULL;
                state  <= S_DONE;
              end else if (fill == '0) begin
                state <= S_INS_PUT;
              end else begin
                state <= S_INS_RD;
              end
            end else begin
              k <= '0;
              if (fill == '0) begin
                status <= ST_NOT_FOUND;
                state  <= S_DONE;
              end else begin
                state <= S_DEL_RD;
              end
            end
          end
        end
        S_INS_RD: begin
          state <= S_INS_CMP;
        end
        S_INS_CMP: begin
          // entry not smaller than the new value moves up one place
          if (rdata >= val) begin
            k     <= k_dec;
            state <= (k_dec == '0) ? S_INS_PUT : S_INS_RD;
          end else begin
            state <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          fill   <= fill + CNT_W'(1);
          status <= ST_INSERTED;
          state  <= S_DONE;
        end
        S_DEL_RD: begin
          state <= S_DEL_CMP;
        end
        S_DEL_CMP: begin
          if (rdata < val) begin
            if (k_inc == fill) begin
              status <= ST_NOT_FOUND;
              state  <= S_DONE;
            end else begin
              k     <= k_inc;
              state <= S_DEL_RD;
            end
          end else if (rdata == val) begin
            if (k_inc == fill) begin
              fill   <= fill - CNT_W'(1);
              status <= ST_DELETED;
              state  <= S_DONE;
            end else begin
              state <= S_SHF_RD;
            end
          end else begin
            status <= ST_NOT_FOUND;
            state  <= S_DONE;
          end
        end
        S_SHF_RD: begin
          state <= S_SHF_WR;
        end
        S_SHF_WR: begin
          // tail entry k+1 now sits at k
          if (k_inc2 == fill) begin
            fill   <= fill - CNT_W'(1);
            status <= ST_DELETED;
            state  <= S_DONE;
          end else begin
            k     <= k_inc;
            state <= S_SHF_RD;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state != S_IDLE);
  assign done            = (state == S_DONE);
  assign result.status   = status;
  assign result.count    = 5'(fill);
  assign result.smallest = (fill != '0) ? head : 32'sd0;

  // result cycle always closes the command
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe held past one cycle");

  // table never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // an accepted command locks out the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken without going busy");

  // full report only with a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_FULL)) |-> (fill == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  // fill moves by at most one per command and only at its end
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_INS_PUT && state != S_DEL_CMP && state != S_SHF_WR) |=> $stable(fill))
    else $error("fill changed outside an update step");

endmodule

// File: rtl/stid_store.sv
// entry memory of the sorted table: one write port, one registered read port
// plus a copy of position zero; depends on stid_pkg
module stid_store (
  input  logic                      clk,
  input  stid_pkg::wr_t             wr,
  input  logic [stid_pkg::IDX_W-1:0] raddr,
  output logic signed [31:0]        rdata,
  output logic signed [31:0]        head
);
  import stid_pkg::*;

  logic signed [31:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

  // position zero mirrored so the smallest value is always at hand
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == '0)) begin
      head <= wr.data;
    end
  end

endmodule

// File: test/tb.sv
// testbench for sorted_table_insert_delete_unit: directed and random insert/delete beats
// checked against a shadow sorted table held in a small scoreboard class
// depends on stid_pkg and the rtl of sorted_table_insert_delete_unit
`timescale 1ns / 1ps

module tb;
  import stid_pkg::*;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 80;     // longer than the slowest delete walk
  localparam int ITEMS_PER_PHASE = 650;
  localparam int MAX_REPORTS  = 40;

  // shadow copy of the sorted table plus the queue of predicted result beats
  class table_checker;
    logic signed [31:0] shadow[CAPACITY];
    int unsigned        shadow_fill;
    out_t               predicted[$];
    int                 errors;

    function new();
      shadow_fill = 0;
      errors = 0;
      foreach (shadow[i]) shadow[i] = '0;
    endfunction

    function int unsigned fill_level();
      return shadow_fill;
    endfunction

    function logic signed [31:0] entry_at(int unsigned i);
      return shadow[i];
    endfunction

    function int outstanding();
      return predicted.size();
    endfunction

    // apply one accepted command beat to the shadow table, queue its result
    function void note_command(in_t c);
      int unsigned pos;
      out_t r;
      pos = 0;
      r = '0;
      if (c.action == ACT_INSERT && shadow_fill >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // first stored entry that is not smaller than the value
        while (pos < shadow_fill && shadow[pos] < c.value) pos++;
        if (c.action == ACT_INSERT) begin
          for (int k = shadow_fill; k > pos; k--) shadow[k] = shadow[k-1];
          shadow[pos] = c.value;
          shadow_fill++;
          r.status = ST_INSERTED;
        end else if (pos < shadow_fill && shadow[pos] == c.value) begin
          for (int k = pos; k + 1 < shadow_fill; k++) shadow[k] = shadow[k+1];
          shadow_fill--;
          r.status = ST_DELETED;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      r.count    = shadow_fill[4:0];
      r.smallest = (shadow_fill > 0) ? shadow[0] : '0;
      predicted.push_back(r);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t mismatch %s: expected %0h actual %0h", $time, what, want, got);
    endfunction

    // compare one result beat with the oldest prediction
    function void check_result(out_t got);
      out_t want;
      if (predicted.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t unexpected result: expected none actual %0h", $time, got);
        return;
      end
      want = predicted.pop_front();
      if (got.status !== want.status)     flag("status", want.status, got.status);
      if (got.count !== want.count)       flag("count", want.count, got.count);
      if (got.smallest !== want.smallest) flag("smallest", want.smallest, got.smallest);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  in_t  cmd;
  logic busy;
  logic done;
  out_t result;

  table_checker sb = new();
  int   cycles;
  int   idle_pct;          // per-cycle chance that the sender holds off
  int   insert_pct;        // insert bias of the current random stretch

  sorted_table_insert_delete_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // monitor: results are checked first, then an accepted command beat is
  // folded into the shadow table; busy covers the result cycle, so the two
  // never land on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_command(cmd);
    end
  end

  // sender hold-off after a beat: short random gaps, now and then a long one
  // so that the next start lands on any cycle of the walk
  task automatic sender_gap();
    if (idle_pct > 0 && $urandom_range(7) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
  endtask

  // present one command beat at a falling edge, hold it until taken
  task automatic send_command(input logic act, input logic signed [31:0] v);
    cmd.action = act;
    cmd.value  = v;
    start      = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sender_gap();
  endtask

  // value mix: a small pool for duplicates and hits, stored values for
  // deletes that find something, the extremes, and fully random words
  function automatic logic signed [31:0] pick_value(logic act);
    int r;
    int unsigned n;
    r = $urandom_range(99);
    n = sb.fill_level();
    if (r < 45) return $signed($urandom_range(0, 16)) - 8;
    if (r < 65 && act == ACT_DELETE && n > 0) return sb.entry_at($urandom_range(0, n - 1));
    if (r < 80) begin
      case ($urandom_range(5))
        0: return VAL_MIN;
        1: return VAL_MIN + 1;
        2: return VAL_MAX;
        3: return VAL_MAX - 1;
        4: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic random_phase(input int pct);
    logic act;
    idle_pct = pct;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      // stretches of inserts and deletes swing the table between empty and full
      if (i % 24 == 0) begin
        case ($urandom_range(3))
          0: insert_pct = 15;
          1: insert_pct = 50;
          2: insert_pct = 85;
          default: insert_pct = 100;
        endcase
      end
      act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_DELETE;
      send_command(act, pick_value(act));
    end
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    cmd      = '0;
    idle_pct = 0;
    insert_pct = 50;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: delete on an empty table
    send_command(ACT_DELETE, '0);
    // extremes, zero, minus one and duplicates, going in out of order
    send_command(ACT_INSERT, VAL_MAX);
    send_command(ACT_INSERT, VAL_MIN);
    send_command(ACT_INSERT, '0);
    send_command(ACT_INSERT, -1);
    send_command(ACT_INSERT, '0);
    send_command(ACT_INSERT, VAL_MIN);
    send_command(ACT_INSERT, 1);
    // fill up to capacity
    for (int i = 0; i < CAPACITY - 7; i++) send_command(ACT_INSERT, 400 - 100 * i);
    // insert into a full table is dropped
    send_command(ACT_INSERT, 5);
    // missing value
    send_command(ACT_DELETE, 12345);
    // delete at both ends and a duplicate pair, then the value once more
    send_command(ACT_DELETE, VAL_MIN);
    send_command(ACT_DELETE, VAL_MAX);
    send_command(ACT_DELETE, '0);
    send_command(ACT_DELETE, '0);
    send_command(ACT_DELETE, '0);

    // random: sender busy-ish, then mostly idle, then back to back
    random_phase(36);
    random_phase(60);
    random_phase(0);
    start = 1'b0;

    // drain outstanding results, then watch a while for strays
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/stid_pkg.sv
rtl/stid_store.sv
rtl/sorted_table_insert_delete_unit.sv
test/tb.sv
